[hw/rtl/npc_pkg.sv]
// shared types, codes and constants for the nunchuk poll controller
package npc_pkg;

    localparam int FRAME_BYTES = 6;
    localparam int FRAME_W     = 8 * FRAME_BYTES;

    typedef enum logic [2:0] {
        OP_RESTART   = 3'd0,
        OP_TICK      = 3'd1,
        OP_READ_REQ  = 3'd2,
        OP_WRITE_DONE = 3'd3,
        OP_READ_DONE = 3'd4,
        OP_BUS_ERROR = 3'd5,
        OP_PROCESS   = 3'd6
    } op_t;

    typedef enum logic [4:0] {
        MODE_UNINIT  = 5'b00001,
        MODE_INIT    = 5'b00010,
        MODE_READY   = 5'b00100,
        MODE_READING = 5'b01000,
        MODE_ERROR   = 5'b10000
    } mode_t;

    localparam logic [2:0] CS_UNINIT  = 3'd0;
    localparam logic [2:0] CS_INIT    = 3'd1;
    localparam logic [2:0] CS_READY   = 3'd2;
    localparam logic [2:0] CS_READING = 3'd3;
    localparam logic [2:0] CS_ERROR   = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_READY = 3'd1;
    localparam logic [2:0] ST_BUSY      = 3'd2;
    localparam logic [2:0] ST_NO_DATA   = 3'd3;
    localparam logic [2:0] ST_ERR       = 3'd4;
    localparam logic [2:0] ST_TIMEOUT   = 3'd5;
    localparam logic [2:0] ST_BAD       = 3'd6;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [2:0] CFG_TYPE       = 3'd0;
    localparam logic [2:0] CFG_MAX_ERRORS = 3'd1;
    localparam logic [2:0] CFG_INIT_TO    = 3'd2;
    localparam logic [2:0] CFG_READ_TO    = 3'd3;
    localparam logic [2:0] CFG_RECOVER    = 3'd4;
    localparam logic [2:0] CFG_XOR        = 3'd5;
    localparam logic [2:0] CFG_ADD        = 3'd6;

    localparam logic [15:0] BLACK_STEP0 = 16'hF055;
    localparam logic [15:0] BLACK_STEP1 = 16'hFB00;
    localparam logic [15:0] WHITE_STEP0 = 16'h4000;
    localparam logic [15:0] WHITE_STEP1 = 16'h0000;
    localparam logic [15:0] READ_POINTER = 16'h0000;

    typedef struct packed {
        logic        nunchuk_type;
        logic [7:0]  max_errors;
        logic [15:0] init_timeout_ms;
        logic [15:0] read_timeout_ms;
        logic [15:0] recover_delay_ms;
        logic [7:0]  decode_xor;
        logic [7:0]  decode_add;
    } cfg_t;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [31:0]        now_ms;
        logic [FRAME_W-1:0] rx_frame;
        logic               start_accepted;
    } item_t;

    typedef struct packed {
        logic [7:0] joy_x;
        logic [7:0] joy_y;
        logic [9:0] accel_x;
        logic [9:0] accel_y;
        logic [9:0] accel_z;
        logic [1:0] buttons;
        logic       valid;
    } sample_t;

    typedef struct packed {
        logic [2:0]  ctrl_state;
        logic [2:0]  status;
        logic [1:0]  issue_kind;
        logic [1:0]  issue_len;
        logic [15:0] issue_bytes;
        sample_t     sample;
    } result_t;

    function automatic logic [2:0] mode_code(mode_t m);
        logic [2:0] c;
        unique case (m)
            MODE_UNINIT:  c = CS_UNINIT;
            MODE_INIT:    c = CS_INIT;
            MODE_READY:   c = CS_READY;
            MODE_READING: c = CS_READING;
            MODE_ERROR:   c = CS_ERROR;
            default:      c = CS_UNINIT;
        endcase
        return c;
    endfunction

endpackage

[hw/rtl/npc_if.sv]
// request channel interfaces: input items, results and register writes
interface npc_item_if;
    import npc_pkg::*;
    logic               valid;
    logic               ready;
    logic [2:0]         opcode;
    logic [31:0]        now_ms;
    logic [FRAME_W-1:0] rx_frame;
    logic               start_accepted;
    modport source (output valid, opcode, now_ms, rx_frame, start_accepted, input ready);
    modport sink (input valid, opcode, now_ms, rx_frame, start_accepted, output ready);
endinterface

interface npc_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  ctrl_state;
    logic [2:0]  status;
    logic [1:0]  issue_kind;
    logic [1:0]  issue_len;
    logic [15:0] issue_bytes;
    logic [7:0]  joy_x;
    logic [7:0]  joy_y;
    logic [9:0]  accel_x;
    logic [9:0]  accel_y;
    logic [9:0]  accel_z;
    logic [1:0]  buttons;
    logic        sample_valid;
    modport source (output valid, ctrl_state, status, issue_kind, issue_len, issue_bytes,
                    joy_x, joy_y, accel_x, accel_y, accel_z, buttons, sample_valid,
                    input ready);
    modport sink (input valid, ctrl_state, status, issue_kind, issue_len, issue_bytes,
                  joy_x, joy_y, accel_x, accel_y, accel_z, buttons, sample_valid,
                  output ready);
endinterface

interface npc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/nunchuk_poll_controller.sv]
// top level: input register, controller core, result register and config port
// result path: the accepted request is held in the input register, and its result in the result register
// throughput: one request per cycle while no result waits unread; the whole state update is one pass of the core logic
// a result waiting in the output register stalls the core; one more request can enter
// reset: asynchronous, clears all controller state and loads register defaults
// no memory clearing pass after reset
module nunchuk_poll_controller (
    input  logic          clk,
    input  logic          rst_n,
    npc_item_if.sink      item,
    npc_result_if.source  result,
    npc_cfg_if.sink       cfg
);
    import npc_pkg::*;

    item_t   item_reg;
    logic    item_valid_reg;
    result_t res_reg;
    logic    res_valid_reg;
    result_t core_res;
    cfg_t    cfg_regs;
    logic    advance;

    assign advance    = item_valid_reg && (!res_valid_reg || result.ready);
    assign item.ready = !item_valid_reg || advance;

    npc_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (cfg_regs)
    );

    npc_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg_regs),
        .res     (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (item.ready)
                item_valid_reg <= item.valid;
            if (advance)
                res_valid_reg <= 1'b1;
            else if (result.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            item_reg.opcode         <= item.opcode;
            item_reg.now_ms         <= item.now_ms;
            item_reg.rx_frame       <= item.rx_frame;
            item_reg.start_accepted <= item.start_accepted;
        end
        if (advance)
            res_reg <= core_res;
    end

    assign result.valid        = res_valid_reg;
    assign result.ctrl_state   = res_reg.ctrl_state;
    assign result.status       = res_reg.status;
    assign result.issue_kind   = res_reg.issue_kind;
    assign result.issue_len    = res_reg.issue_len;
    assign result.issue_bytes  = res_reg.issue_bytes;
    assign result.joy_x        = res_reg.sample.joy_x;
    assign result.joy_y        = res_reg.sample.joy_y;
    assign result.accel_x      = res_reg.sample.accel_x;
    assign result.accel_y      = res_reg.sample.accel_y;
    assign result.accel_z      = res_reg.sample.accel_z;
    assign result.buttons      = res_reg.sample.buttons;
    assign result.sample_valid = res_reg.sample.valid;

endmodule

[hw/rtl/npc_cfg_regs.sv]
// configuration register bank
module npc_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    npc_cfg_if.sink       cfg,
    output npc_pkg::cfg_t regs
);
    import npc_pkg::*;

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_TYPE:       regs_next.nunchuk_type     = cfg.data[0];
                CFG_MAX_ERRORS: regs_next.max_errors       = cfg.data[7:0];
                CFG_INIT_TO:    regs_next.init_timeout_ms  = cfg.data;
                CFG_READ_TO:    regs_next.read_timeout_ms  = cfg.data;
                CFG_RECOVER:    regs_next.recover_delay_ms = cfg.data;
                CFG_XOR:        regs_next.decode_xor       = cfg.data[7:0];
                CFG_ADD:        regs_next.decode_add       = cfg.data[7:0];
                default:        regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.nunchuk_type     <= 1'b0;
            regs_reg.max_errors       <= 8'd5;
            regs_reg.init_timeout_ms  <= 16'd5000;
            regs_reg.read_timeout_ms  <= 16'd1000;
            regs_reg.recover_delay_ms <= 16'd2000;
            regs_reg.decode_xor       <= 8'd23;
            regs_reg.decode_add       <= 8'd23;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

[hw/rtl/npc_frame_dec.sv]
// frame check and byte decode of a captured six-byte frame
module npc_frame_dec (
    input  logic [npc_pkg::FRAME_W-1:0] raw,
    input  logic [7:0]                  xor_key,
    input  logic [7:0]                  add_key,
    output logic                        frame_ok,
    output npc_pkg::sample_t            sample
);
    import npc_pkg::*;

    logic [7:0] b [FRAME_BYTES];
    logic [7:0] d [FRAME_BYTES];
    logic [FRAME_BYTES-1:0] diff;

    always_comb
    begin
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            b[i]    = raw[FRAME_W-1-8*i -: 8];
            d[i]    = (b[i] ^ xor_key) + add_key;
            diff[i] = (b[i] != b[0]);
        end
    end

    assign frame_ok = |diff;

    always_comb
    begin
        sample.joy_x   = d[0];
        sample.joy_y   = d[1];
        sample.accel_x = {d[2], d[5][3:2]};
        sample.accel_y = {d[3], d[5][5:4]};
        sample.accel_z = {d[4], d[5][7:6]};
        sample.buttons = {~d[5][1], ~d[5][0]};
        sample.valid   = 1'b1;
    end

endmodule

[hw/rtl/npc_core.sv]
// controller state and single-pass next-state and result logic
module npc_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  npc_pkg::item_t   item,
    input  npc_pkg::cfg_t    cfg,
    output npc_pkg::result_t res
);
    import npc_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic        start;
        logic [1:0]  len;
        logic [15:0] bytes;
        logic [7:0]  tally;
        logic        to_error;
    } init_res_t;

    mode_t               mode_reg, mode_next;
    logic [1:0]          idx_reg, idx_next;
    logic [7:0]          tally_reg, tally_next;
    logic                idle_reg, idle_next;
    logic                pend_reg, pend_next;
    logic [31:0]         dead_reg, dead_next;
    logic [31:0]         last_reg, last_next;
    logic [FRAME_W-1:0]  raw_reg, raw_next;
    sample_t             samp_reg, samp_next;

    logic    frame_ok;
    sample_t dec_sample;

    npc_frame_dec u_dec (
        .raw      (raw_reg),
        .xor_key  (cfg.decode_xor),
        .add_key  (cfg.decode_add),
        .frame_ok (frame_ok),
        .sample   (dec_sample)
    );

    function automatic logic [7:0] sat_inc(logic [7:0] v);
        return (v != 8'hFF) ? v + 8'd1 : v;
    endfunction

    function automatic init_res_t next_init_write(logic [1:0] idx, logic [7:0] tally,
                                                  logic acc, logic typ, logic [7:0] maxe);
        init_res_t r;
        r.status   = ST_OK;
        r.start    = 1'b0;
        r.len      = 2'd2;
        r.bytes    = BLACK_STEP0;
        r.tally    = tally;
        r.to_error = 1'b0;
        if (typ)
        begin
            r.len   = idx[0] ? 2'd1 : 2'd2;
            r.bytes = idx[0] ? WHITE_STEP1 : WHITE_STEP0;
        end
        else
        begin
            r.bytes = idx[0] ? BLACK_STEP1 : BLACK_STEP0;
        end
        if (idx[1])
        begin
            r.status = ST_BAD;
        end
        else if (!acc)
        begin
            r.tally    = sat_inc(tally);
            r.to_error = (r.tally >= maxe);
            r.status   = ST_ERR;
        end
        else
        begin
            r.start = 1'b1;
        end
        return r;
    endfunction

    logic        do_restart;
    logic        do_init;
    logic        keep_status;
    logic [31:0] past;
    logic [31:0] since;
    init_res_t   ir;
    logic [2:0]  st;
    logic [1:0]  kind;
    logic [1:0]  len;
    logic [15:0] bytes;

    always_comb
    begin
        mode_next   = mode_reg;
        idx_next    = idx_reg;
        tally_next  = tally_reg;
        idle_next   = idle_reg;
        pend_next   = pend_reg;
        dead_next   = dead_reg;
        last_next   = last_reg;
        raw_next    = raw_reg;
        samp_next   = samp_reg;
        st          = ST_OK;
        kind        = KIND_NONE;
        len         = 2'd0;
        bytes       = 16'd0;
        do_restart  = 1'b0;
        do_init     = 1'b0;
        keep_status = 1'b0;
        past        = item.now_ms - dead_reg;
        since       = item.now_ms - last_reg;
        ir          = '0;

        unique case (item.opcode)
            OP_RESTART:
            begin
                do_restart = 1'b1;
            end
            OP_TICK:
            begin
                if (mode_reg == MODE_INIT)
                begin
                    if (past != 32'd0 && !past[31])
                    begin
                        mode_next = MODE_ERROR;
                        st        = ST_TIMEOUT;
                    end
                end
                else if (mode_reg == MODE_READING)
                begin
                    if (since > {16'd0, cfg.read_timeout_ms})
                    begin
                        mode_next  = MODE_READY;
                        idle_next  = 1'b1;
                        tally_next = sat_inc(tally_reg);
                    end
                end
                else if (mode_reg == MODE_ERROR)
                begin
                    if (since > {16'd0, cfg.recover_delay_ms})
                        do_restart = 1'b1;
                end
            end
            OP_READ_REQ:
            begin
                if (mode_reg != MODE_READY)
                    st = ST_NOT_READY;
                else if (!idle_reg)
                    st = ST_BUSY;
                else if (!item.start_accepted)
                begin
                    tally_next = sat_inc(tally_reg);
                    st         = ST_ERR;
                end
                else
                begin
                    kind      = KIND_WRITE;
                    len       = 2'd1;
                    bytes     = READ_POINTER;
                    idle_next = 1'b0;
                    mode_next = MODE_READING;
                    last_next = item.now_ms;
                end
            end
            OP_WRITE_DONE:
            begin
                idle_next = 1'b1;
                if (mode_reg == MODE_INIT)
                begin
                    if (idx_reg != 2'd3)
                        idx_next = idx_reg + 2'd1;
                    if (!idx_next[1])
                        do_init = 1'b1;
                    else
                    begin
                        mode_next = MODE_READY;
                        last_next = item.now_ms;
                    end
                end
                else if (mode_reg == MODE_READING)
                begin
                    if (!item.start_accepted)
                    begin
                        mode_next  = MODE_READY;
                        tally_next = sat_inc(tally_reg);
                        st         = ST_ERR;
                    end
                    else
                    begin
                        kind      = KIND_READ;
                        idle_next = 1'b0;
                    end
                end
            end
            OP_READ_DONE:
            begin
                raw_next  = item.rx_frame;
                idle_next = 1'b1;
                pend_next = 1'b1;
                mode_next = MODE_READY;
            end
            OP_BUS_ERROR:
            begin
                idle_next  = 1'b1;
                tally_next = sat_inc(tally_reg);
                st         = ST_ERR;
                if (tally_next >= cfg.max_errors)
                    mode_next = MODE_ERROR;
                else if (mode_reg == MODE_INIT)
                begin
                    do_init     = 1'b1;
                    keep_status = 1'b1;
                end
                else
                    mode_next = MODE_READY;
            end
            OP_PROCESS:
            begin
                if (!pend_reg)
                    st = ST_NO_DATA;
                else if (frame_ok)
                begin
                    samp_next  = dec_sample;
                    pend_next  = 1'b0;
                    last_next  = item.now_ms;
                    tally_next = 8'd0;
                end
                else
                begin
                    samp_next.valid = 1'b0;
                    pend_next       = 1'b0;
                    tally_next      = sat_inc(tally_reg);
                    if (tally_next >= cfg.max_errors)
                        mode_next = MODE_ERROR;
                    st = ST_ERR;
                end
            end
            default:
            begin
                st = ST_BAD;
            end
        endcase

        if (do_restart)
        begin
            mode_next  = MODE_INIT;
            idx_next   = 2'd0;
            tally_next = 8'd0;
            idle_next  = 1'b1;
            pend_next  = 1'b0;
            last_next  = 32'd0;
            raw_next   = '0;
            samp_next  = '0;
            dead_next  = item.now_ms + {16'd0, cfg.init_timeout_ms};
            do_init    = 1'b1;
        end

        if (do_init)
        begin
            ir = next_init_write(idx_next, tally_next, item.start_accepted,
                                 cfg.nunchuk_type, cfg.max_errors);
            tally_next = ir.tally;
            if (ir.to_error)
                mode_next = MODE_ERROR;
            if (ir.start)
            begin
                idle_next = 1'b0;
                kind      = KIND_WRITE;
                len       = ir.len;
                bytes     = ir.bytes;
            end
            if (!keep_status)
                st = ir.status;
        end
    end

    always_comb
    begin
        res.ctrl_state  = mode_code(mode_next);
        res.status      = st;
        res.issue_kind  = kind;
        res.issue_len   = len;
        res.issue_bytes = bytes;
        res.sample      = samp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_UNINIT;
            idx_reg   <= 2'd0;
            tally_reg <= 8'd0;
            idle_reg  <= 1'b1;
            pend_reg  <= 1'b0;
            dead_reg  <= 32'd0;
            last_reg  <= 32'd0;
            raw_reg   <= '0;
            samp_reg  <= '0;
        end
        else if (advance)
        begin
            mode_reg  <= mode_next;
            idx_reg   <= idx_next;
            tally_reg <= tally_next;
            idle_reg  <= idle_next;
            pend_reg  <= pend_next;
            dead_reg  <= dead_next;
            last_reg  <= last_next;
            raw_reg   <= raw_next;
            samp_reg  <= samp_next;
        end
    end

`ifndef ASSERT_OFF
    a_issue_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.issue_kind != KIND_NONE |-> item.start_accepted)
        else $error("transfer issued without master acceptance");

    a_read_done_ready: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.opcode == OP_READ_DONE |=> pend_reg && idle_reg
            && mode_reg == MODE_READY)
        else $error("read done did not leave a pending frame in ready");

    a_len_only_write: assert property (@(posedge clk) disable iff (!rst_n)
        res.issue_len != 2'd0 |-> res.issue_kind == KIND_WRITE)
        else $error("write length without a write");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.opcode == OP_RESTART |=> !pend_reg && !samp_reg.valid
            && idx_reg == 2'd0)
        else $error("restart left stale frame state");
`endif

endmodule

[tb/tb_nunchuk_poll_controller.sv]
// self-checking testbench for the nunchuk poll controller: request traffic, register phases
module tb_nunchuk_poll_controller;
    timeunit 1ns;
    timeprecision 1ps;

    import npc_pkg::*;

    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int LIMIT_CYCLES = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int CALM_FROM = 900;
    localparam int CALM_TO = 1200;
    localparam int HOLD_AT = 500;
    localparam int HOLD_CYCLES = 400;

    class poll_scoreboard;
        logic               white_type;
        logic [7:0]         err_limit;
        logic [15:0]        init_to_ms;
        logic [15:0]        read_to_ms;
        logic [15:0]        recover_ms;
        logic [7:0]         dec_xor;
        logic [7:0]         dec_add;
        logic [2:0]         mode;
        logic [1:0]         step_idx;
        logic [7:0]         tally;
        bit                 bus_idle;
        bit                 frame_waiting;
        logic [31:0]        deadline_ms;
        logic [31:0]        activity_ms;
        logic [FRAME_W-1:0] frame_buf;
        sample_t            held;
        result_t            outcome;
        result_t            expected_reports[$];
        int                 mismatches;
        int                 checked;

        function new();
            white_type = 1'b0;
            err_limit = 8'd5;
            init_to_ms = 16'd5000;
            read_to_ms = 16'd1000;
            recover_ms = 16'd2000;
            dec_xor = 8'd23;
            dec_add = 8'd23;
            mode = CS_UNINIT;
            step_idx = '0;
            tally = '0;
            bus_idle = 1'b1;
            frame_waiting = 1'b0;
            deadline_ms = '0;
            activity_ms = '0;
            frame_buf = '0;
            held = '0;
            mismatches = 0;
            checked = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                CFG_TYPE:       white_type = data[0];
                CFG_MAX_ERRORS: err_limit = data[7:0];
                CFG_INIT_TO:    init_to_ms = data;
                CFG_READ_TO:    read_to_ms = data;
                CFG_RECOVER:    recover_ms = data;
                CFG_XOR:        dec_xor = data[7:0];
                CFG_ADD:        dec_add = data[7:0];
                default:        ;
            endcase
        endfunction

        function void bump_tally();
            if (tally != 8'hFF)
                tally++;
        endfunction

        function logic [2:0] init_write(bit acc);
            logic [1:0]  len;
            logic [15:0] bytes;
            if (step_idx >= 2)
                return ST_BAD;
            if (white_type)
            begin
                len = (step_idx == 0) ? 2'd2 : 2'd1;
                bytes = (step_idx == 0) ? WHITE_STEP0 : WHITE_STEP1;
            end
            else
            begin
                len = 2'd2;
                bytes = (step_idx == 0) ? BLACK_STEP0 : BLACK_STEP1;
            end
            if (!acc)
            begin
                bump_tally();
                if (tally >= err_limit)
                    mode = CS_ERROR;
                return ST_ERR;
            end
            outcome.issue_kind = KIND_WRITE;
            outcome.issue_len = len;
            outcome.issue_bytes = bytes;
            bus_idle = 1'b0;
            return ST_OK;
        endfunction

        function logic [2:0] restart(logic [31:0] now, bit acc);
            mode = CS_INIT;
            step_idx = '0;
            tally = '0;
            bus_idle = 1'b1;
            frame_waiting = 1'b0;
            activity_ms = '0;
            frame_buf = '0;
            held = '0;
            deadline_ms = now + {16'd0, init_to_ms};
            return init_write(acc);
        endfunction

        function void unpack_frame();
            logic [7:0] d [FRAME_BYTES];
            for (int i = 0; i < FRAME_BYTES; i++)
                d[i] = (frame_buf[FRAME_W-1-8*i -: 8] ^ dec_xor) + dec_add;
            held.joy_x = d[0];
            held.joy_y = d[1];
            held.accel_x = {d[2], d[5][3:2]};
            held.accel_y = {d[3], d[5][5:4]};
            held.accel_z = {d[4], d[5][7:6]};
            held.buttons = {~d[5][1], ~d[5][0]};
        endfunction

        // works out the result of one accepted request
        function void note_request(logic [2:0] op, logic [31:0] now,
                                   logic [FRAME_W-1:0] rx, bit acc);
            logic [2:0]  st;
            logic [31:0] past;
            st = ST_OK;
            outcome = '0;
            case (op)
                OP_RESTART:
                    st = restart(now, acc);
                OP_TICK:
                begin
                    if (mode == CS_INIT)
                    begin
                        past = now - deadline_ms;
                        if (past != 0 && !past[31])
                        begin
                            mode = CS_ERROR;
                            st = ST_TIMEOUT;
                        end
                    end
                    else if (mode == CS_READING)
                    begin
                        past = now - activity_ms;
                        if (past > {16'd0, read_to_ms})
                        begin
                            mode = CS_READY;
                            bus_idle = 1'b1;
                            bump_tally();
                        end
                    end
                    else if (mode == CS_ERROR)
                    begin
                        past = now - activity_ms;
                        if (past > {16'd0, recover_ms})
                            st = restart(now, acc);
                    end
                end
                OP_READ_REQ:
                begin
                    if (mode != CS_READY)
                        st = ST_NOT_READY;
                    else if (!bus_idle)
                        st = ST_BUSY;
                    else if (!acc)
                    begin
                        bump_tally();
                        st = ST_ERR;
                    end
                    else
                    begin
                        outcome.issue_kind = KIND_WRITE;
                        outcome.issue_len = 2'd1;
                        outcome.issue_bytes = READ_POINTER;
                        bus_idle = 1'b0;
                        mode = CS_READING;
                        activity_ms = now;
                    end
                end
                OP_WRITE_DONE:
                begin
                    bus_idle = 1'b1;
                    if (mode == CS_INIT)
                    begin
                        if (step_idx < 3)
                            step_idx++;
                        if (step_idx < 2)
                            st = init_write(acc);
                        else
                        begin
                            mode = CS_READY;
                            activity_ms = now;
                        end
                    end
                    else if (mode == CS_READING)
                    begin
                        if (!acc)
                        begin
                            mode = CS_READY;
                            bump_tally();
                            st = ST_ERR;
                        end
                        else
                        begin
                            outcome.issue_kind = KIND_READ;
                            bus_idle = 1'b0;
                        end
                    end
                end
                OP_READ_DONE:
                begin
                    frame_buf = rx;
                    bus_idle = 1'b1;
                    frame_waiting = 1'b1;
                    mode = CS_READY;
                end
                OP_BUS_ERROR:
                begin
                    bus_idle = 1'b1;
                    bump_tally();
                    if (tally >= err_limit)
                        mode = CS_ERROR;
                    else if (mode == CS_INIT)
                        void'(init_write(acc));
                    else
                        mode = CS_READY;
                    st = ST_ERR;
                end
                OP_PROCESS:
                begin
                    if (!frame_waiting)
                        st = ST_NO_DATA;
                    else if (frame_buf != {FRAME_BYTES{frame_buf[FRAME_W-1 -: 8]}})
                    begin
                        unpack_frame();
                        held.valid = 1'b1;
                        frame_waiting = 1'b0;
                        activity_ms = now;
                        tally = '0;
                    end
                    else
                    begin
                        // all six bytes equal
                        held.valid = 1'b0;
                        frame_waiting = 1'b0;
                        bump_tally();
                        if (tally >= err_limit)
                            mode = CS_ERROR;
                        st = ST_ERR;
                    end
                end
                default:
                    st = ST_BAD;
            endcase
            outcome.ctrl_state = mode;
            outcome.status = st;
            outcome.sample = held;
            expected_reports.push_back(outcome);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] seen);
            if (want !== seen)
            begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, seen);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            checked++;
            if (expected_reports.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none actual %0h", $time, got);
                return;
            end
            want = expected_reports.pop_front();
            compare_field("ctrl_state", 16'(want.ctrl_state), 16'(got.ctrl_state));
            compare_field("status", 16'(want.status), 16'(got.status));
            compare_field("issue_kind", 16'(want.issue_kind), 16'(got.issue_kind));
            compare_field("issue_len", 16'(want.issue_len), 16'(got.issue_len));
            compare_field("issue_bytes", want.issue_bytes, got.issue_bytes);
            compare_field("joy_x", 16'(want.sample.joy_x), 16'(got.sample.joy_x));
            compare_field("joy_y", 16'(want.sample.joy_y), 16'(got.sample.joy_y));
            compare_field("accel_x", 16'(want.sample.accel_x), 16'(got.sample.accel_x));
            compare_field("accel_y", 16'(want.sample.accel_y), 16'(got.sample.accel_y));
            compare_field("accel_z", 16'(want.sample.accel_z), 16'(got.sample.accel_z));
            compare_field("buttons", 16'(want.sample.buttons), 16'(got.sample.buttons));
            compare_field("sample_valid", 16'(want.sample.valid), 16'(got.sample.valid));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    npc_item_if   item_if();
    npc_result_if result_if();
    npc_cfg_if    cfg_if();

    poll_scoreboard sb;
    int             sent;
    logic [31:0]    clock_ms;
    logic [2:0]     last_op;

    nunchuk_poll_controller i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    initial
        clk = 1'b0;

    always #5 clk = ~clk;

    task automatic send_request(input logic [2:0] op, input logic [31:0] now,
                                input logic [FRAME_W-1:0] rx, input bit acc);
        if (sent < CALM_FROM || sent >= CALM_TO)
            while ($urandom_range(99) < 38)
            begin
                item_if.valid <= 1'b0;
                @(posedge clk);
            end
        item_if.valid <= 1'b1;
        item_if.opcode <= op;
        item_if.now_ms <= now;
        item_if.rx_frame <= rx;
        item_if.start_accepted <= acc;
        @(posedge clk);
        while (!item_if.ready)
            @(posedge clk);
        sb.note_request(op, now, rx, acc);
        sent++;
    endtask

    task automatic settle();
        item_if.valid <= 1'b0;
        while (sb.expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_settings(input cfg_t s);
        logic [2:0]  reg_idx [7];
        logic [15:0] reg_val [7];
        reg_idx = '{CFG_TYPE, CFG_MAX_ERRORS, CFG_INIT_TO, CFG_READ_TO, CFG_RECOVER,
                    CFG_XOR, CFG_ADD};
        reg_val = '{{15'd0, s.nunchuk_type}, {8'd0, s.max_errors}, s.init_timeout_ms,
                    s.read_timeout_ms, s.recover_delay_ms, {8'd0, s.decode_xor},
                    {8'd0, s.decode_add}};
        for (int k = 0; k < 7; k++)
        begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= reg_idx[k];
            cfg_if.data <= reg_val[k];
            @(posedge clk);
            while (!cfg_if.ready)
                @(posedge clk);
            sb.set_reg(reg_idx[k], reg_val[k]);
        end
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_window();
        if ($urandom_range(1) == 0)
            return 16'($urandom_range(1, 300));
        return 16'($urandom_range(1, 65535));
    endfunction

    task automatic directed_checks();
        send_request(OP_TICK, 32'd0, '0, 1'b1);
        send_request(OP_READ_REQ, 32'hFFFF_FFFF, {FRAME_W{1'b1}}, 1'b1);
        send_request(OP_PROCESS, 32'd5, '0, 1'b0);
        send_request(OP_UNUSED, 32'd6, '0, 1'b1);
        // refused first init write, then a bus error retries it
        send_request(OP_RESTART, 32'd100, '0, 1'b0);
        send_request(OP_BUS_ERROR, 32'd110, '0, 1'b1);
        send_request(OP_WRITE_DONE, 32'd120, '0, 1'b1);
        send_request(OP_WRITE_DONE, 32'd130, '0, 1'b1);
        send_request(OP_READ_REQ, 32'd140, '0, 1'b1);
        send_request(OP_READ_REQ, 32'd150, '0, 1'b1);
        // read timeout
        send_request(OP_TICK, 32'd1141, '0, 1'b1);
        send_request(OP_READ_REQ, 32'd1200, '0, 1'b0);
        send_request(OP_READ_REQ, 32'd1210, '0, 1'b1);
        send_request(OP_WRITE_DONE, 32'd1220, '0, 1'b0);
        send_request(OP_READ_REQ, 32'd1230, '0, 1'b1);
        send_request(OP_WRITE_DONE, 32'd1240, '0, 1'b1);
        send_request(OP_READ_DONE, 32'd1250, 48'h0000_0000_0001, 1'b1);
        send_request(OP_PROCESS, 32'd1260, '0, 1'b1);
        send_request(OP_READ_DONE, 32'd1270, {FRAME_W{1'b1}}, 1'b1);
        send_request(OP_PROCESS, 32'd1280, '0, 1'b1);
        send_request(OP_READ_DONE, 32'd1290, 48'hFFFF_FFFF_FFFE, 1'b1);
        send_request(OP_PROCESS, 32'd1300, '0, 1'b1);
        // init deadline wraps past zero, then times out and recovers
        send_request(OP_RESTART, 32'hFFFF_F000, '0, 1'b1);
        send_request(OP_TICK, 32'h0000_0389, '0, 1'b1);
        send_request(OP_TICK, 32'd3000, '0, 1'b1);
    endtask

    task automatic poll_traffic(input int count);
        logic [2:0]         op;
        logic [FRAME_W-1:0] rx;
        logic [63:0]        rnd;
        bit                 acc;
        int                 roll;
        int                 target;
        target = sent + count;
        while (sent < target)
        begin
            roll = $urandom_range(99);
            if (roll < 3)
                clock_ms = $urandom;
            else if (roll < 10)
                clock_ms += $urandom_range(300, 70000);
            else
                clock_ms += $urandom_range(30);
            acc = ($urandom_range(9) != 0);
            rnd = {$urandom, $urandom};
            rx = rnd[FRAME_W-1:0];
            roll = $urandom_range(99);
            if (roll < 10)
                rx = {FRAME_BYTES{rx[7:0]}};
            else if (roll < 14)
                rx[FRAME_W-1 -: 40] = {5{rx[15:8]}};
            if ($urandom_range(99) < 75)
            begin
                roll = $urandom_range(99);
                case (sb.mode)
                    CS_INIT:
                        op = (roll < 80) ? OP_WRITE_DONE : (roll < 90) ? OP_BUS_ERROR : OP_TICK;
                    CS_READY:
                        op = sb.frame_waiting ? OP_PROCESS : OP_READ_REQ;
                    CS_READING:
                        op = (last_op == OP_WRITE_DONE) ? OP_READ_DONE : OP_WRITE_DONE;
                    default:
                        op = (roll < 40) ? OP_TICK : OP_RESTART;
                endcase
            end
            else
                op = 3'($urandom_range(7));
            send_request(op, clock_ms, rx, acc);
            last_op = op;
        end
    endtask

    initial
    begin : result_sink
        int      hold_left;
        bit      hold_done;
        result_t got;
        hold_left = 0;
        hold_done = 1'b0;
        result_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (result_if.valid && result_if.ready)
            begin
                got.ctrl_state = result_if.ctrl_state;
                got.status = result_if.status;
                got.issue_kind = result_if.issue_kind;
                got.issue_len = result_if.issue_len;
                got.issue_bytes = result_if.issue_bytes;
                got.sample.joy_x = result_if.joy_x;
                got.sample.joy_y = result_if.joy_y;
                got.sample.accel_x = result_if.accel_x;
                got.sample.accel_y = result_if.accel_y;
                got.sample.accel_z = result_if.accel_z;
                got.sample.buttons = result_if.buttons;
                got.sample.valid = result_if.sample_valid;
                sb.check_result(got);
            end
            // one long hold so the block backs up into the request side
            if (!hold_done && sb.checked >= HOLD_AT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_if.ready <= 1'b0;
            end
            else if (sb.checked >= CALM_FROM && sb.checked < CALM_TO)
                result_if.ready <= 1'b1;
            else
                result_if.ready <= ($urandom_range(99) >= 38);
        end
    end

    initial
    begin : watchdog
        for (int c = 0; c < LIMIT_CYCLES; c++)
            @(posedge clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : stimulus
        cfg_t s;
        sb = new();
        sent = 0;
        clock_ms = '0;
        last_op = OP_RESTART;
        rst_n <= 1'b0;
        item_if.valid <= 1'b0;
        item_if.opcode <= OP_RESTART;
        item_if.now_ms <= '0;
        item_if.rx_frame <= '0;
        item_if.start_accepted <= 1'b0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= CFG_TYPE;
        cfg_if.data <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_checks();
        for (int p = 0; p < 6; p++)
        begin
            settle();
            if (p == 0)
            begin
                s.nunchuk_type = 1'b1;
                s.max_errors = 8'd1;
                s.init_timeout_ms = 16'd1;
                s.read_timeout_ms = 16'd1;
                s.recover_delay_ms = 16'd1;
                s.decode_xor = 8'h00;
                s.decode_add = 8'h00;
            end
            else if (p == 1)
            begin
                s.nunchuk_type = 1'b0;
                s.max_errors = 8'd255;
                s.init_timeout_ms = 16'hFFFF;
                s.read_timeout_ms = 16'hFFFF;
                s.recover_delay_ms = 16'hFFFF;
                s.decode_xor = 8'hFF;
                s.decode_add = 8'hFF;
            end
            else
            begin
                s.nunchuk_type = 1'($urandom_range(1));
                s.max_errors = 8'(($urandom_range(1) == 0) ? $urandom_range(1, 8)
                                                           : $urandom_range(1, 255));
                s.init_timeout_ms = pick_window();
                s.read_timeout_ms = pick_window();
                s.recover_delay_ms = pick_window();
                s.decode_xor = 8'($urandom_range(255));
                s.decode_add = 8'($urandom_range(255));
            end
            load_settings(s);
            poll_traffic(320);
        end
        settle();
        if (sb.mismatches == 0 && sb.expected_reports.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/npc_pkg.sv
hw/rtl/npc_if.sv
hw/rtl/npc_cfg_regs.sv
hw/rtl/npc_frame_dec.sv
hw/rtl/npc_core.sv
hw/rtl/nunchuk_poll_controller.sv
tb/tb_nunchuk_poll_controller.sv
